// ===== sv/capu_pkg.sv =====
// Shared constants, table and types for the circle angle unwrap pipeline.
package capu_pkg;

    localparam int CORDIC_STAGES = 26;
    localparam int DATA_W = 32;
    localparam int VEC_W = 44;
    localparam int ANGLE_W = 32;
    localparam int NORM_TARGET = 40;

    typedef enum logic [1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_RADIUS   = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] ref_param;
        logic signed [DATA_W-1:0] lower_limit;
        logic signed [DATA_W-1:0] upper_limit;
        logic                     radius_ok;
        logic                     degenerate;
    } side_t;

    function automatic logic [ANGLE_W-1:0] atan_turns(input int idx);
        logic [ANGLE_W-1:0] val;
        begin
            case (idx)
                0: val = 32'd536870912;
                1: val = 32'd316933406;
                2: val = 32'd167458907;
                3: val = 32'd85004756;
                4: val = 32'd42667331;
                5: val = 32'd21354465;
                6: val = 32'd10679838;
                7: val = 32'd5340245;
                8: val = 32'd2670163;
                9: val = 32'd1335087;
                10: val = 32'd667544;
                11: val = 32'd333772;
                12: val = 32'd166886;
                13: val = 32'd83443;
                14: val = 32'd41722;
                15: val = 32'd20861;
                16: val = 32'd10430;
                17: val = 32'd5215;
                18: val = 32'd2608;
                19: val = 32'd1304;
                20: val = 32'd652;
                21: val = 32'd326;
                22: val = 32'd163;
                23: val = 32'd81;
                24: val = 32'd41;
                25: val = 32'd20;
                26: val = 32'd10;
                27: val = 32'd5;
                28: val = 32'd3;
                29: val = 32'd1;
                30: val = 32'd1;
                default: val = '0;
            endcase
            return val;
        end
    endfunction

endpackage

// ===== sv/capu_cordic.sv =====
// Pipelined CORDIC vectoring unit, one rotation per register stage.
module capu_cordic
    import capu_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic                      in_valid,
    input  logic signed [VEC_W-1:0]   in_x,
    input  logic signed [VEC_W-1:0]   in_y,
    input  logic [ANGLE_W-1:0]        in_z,
    input  side_t                     in_side,
    output logic                      out_valid,
    output logic [ANGLE_W-1:0]        out_z,
    output side_t                     out_side
);

    logic signed [VEC_W-1:0] x_reg [1:CORDIC_STAGES];
    logic signed [VEC_W-1:0] y_reg [1:CORDIC_STAGES];
    logic [ANGLE_W-1:0]      z_reg [1:CORDIC_STAGES];
    side_t                   s_reg [1:CORDIC_STAGES];
    logic [CORDIC_STAGES:1]  v_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        logic signed [VEC_W-1:0] cur_x;
        logic signed [VEC_W-1:0] cur_y;
        logic [ANGLE_W-1:0]      cur_z;
        side_t                   cur_s;
        logic                    cur_v;
        logic signed [VEC_W-1:0] xs;
        logic signed [VEC_W-1:0] ys;

        if (i == 0)
        begin : g_head
            assign cur_x = in_x;
            assign cur_y = in_y;
            assign cur_z = in_z;
            assign cur_s = in_side;
            assign cur_v = in_valid;
        end
        else
        begin : g_link
            assign cur_x = x_reg[i];
            assign cur_y = y_reg[i];
            assign cur_z = z_reg[i];
            assign cur_s = s_reg[i];
            assign cur_v = v_reg[i];
        end

        assign xs = cur_x >>> i;
        assign ys = cur_y >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (advance)
            begin
                v_reg[i+1] <= cur_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                s_reg[i+1] <= cur_s;
                if (!cur_y[VEC_W-1])
                begin
                    x_reg[i+1] <= cur_x + ys;
                    y_reg[i+1] <= cur_y - xs;
                    z_reg[i+1] <= cur_z + atan_turns(i);
                end
                else
                begin
                    x_reg[i+1] <= cur_x - ys;
                    y_reg[i+1] <= cur_y + xs;
                    z_reg[i+1] <= cur_z - atan_turns(i);
                end
            end
        end
    end

    assign out_valid = v_reg[CORDIC_STAGES];
    assign out_z     = z_reg[CORDIC_STAGES];
    assign out_side  = s_reg[CORDIC_STAGES];

endmodule

// ===== sv/circle_angle_parameter_unwrap_top.sv =====
// Top level: offset, normalize, CORDIC, unwrap, saturate and clamp pipeline.
//  channel | valid     | ready     | payload
//  in      | in_valid  | in_ready  | point_x point_y ref_param lower_limit upper_limit
//  out     | out_valid | out_ready | param degenerate
//  cfg     | cfg_valid | cfg_ready | cfg_index cfg_data
// One item per cycle when not stalled; the CORDIC stage count sets the pipeline depth.
// A stall on out_ready freezes every stage together; nothing is lost or repeated.
// Reset clears valid bits and loads center 0, radius 1.0.
module circle_angle_parameter_unwrap_top
    import capu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] point_x,
    input  logic signed [DATA_W-1:0] point_y,
    input  logic signed [DATA_W-1:0] ref_param,
    input  logic signed [DATA_W-1:0] lower_limit,
    input  logic signed [DATA_W-1:0] upper_limit,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] param,
    output logic                     degenerate,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [DATA_W-1:0]        cfg_data
);

    logic signed [DATA_W-1:0] center_x_reg;
    logic signed [DATA_W-1:0] center_y_reg;
    logic signed [DATA_W-1:0] radius_reg;

    logic advance;
    assign advance   = !out_valid || out_ready;
    assign in_ready  = advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= 32'sd65536;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CENTER_X: center_x_reg <= cfg_data;
                REG_CENTER_Y: center_y_reg <= cfg_data;
                REG_RADIUS:   radius_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: offsets
    logic                   s1_valid_reg;
    logic signed [DATA_W:0] s1_dx_reg;
    logic signed [DATA_W:0] s1_dy_reg;
    side_t                  s1_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_dx_reg <= {point_x[DATA_W-1], point_x} - {center_x_reg[DATA_W-1], center_x_reg};
            s1_dy_reg <= {point_y[DATA_W-1], point_y} - {center_y_reg[DATA_W-1], center_y_reg};
            s1_side_reg.ref_param   <= ref_param;
            s1_side_reg.lower_limit <= lower_limit;
            s1_side_reg.upper_limit <= upper_limit;
            s1_side_reg.radius_ok   <= radius_reg > 0;
            s1_side_reg.degenerate  <= 1'b0;
        end
    end

    // stage 2: magnitude, leading-one position and degenerate flag
    logic [DATA_W:0] mag_x;
    logic [DATA_W:0] mag_y;
    logic [DATA_W:0] mag_or;
    logic [5:0]      lead_pos;
    assign mag_x  = s1_dx_reg[DATA_W] ? -s1_dx_reg : s1_dx_reg;
    assign mag_y  = s1_dy_reg[DATA_W] ? -s1_dy_reg : s1_dy_reg;
    assign mag_or = mag_x | mag_y;

    always_comb
    begin
        lead_pos = '0;
        for (int b = 0; b <= DATA_W; b++)
        begin
            if (mag_or[b])
            begin
                lead_pos = 6'(b);
            end
        end
    end

    side_t s2_side_next;

    always_comb
    begin
        s2_side_next            = s1_side_reg;
        s2_side_next.degenerate = (mag_or == '0) && s1_side_reg.radius_ok;
    end

    logic                   s2_valid_reg;
    logic signed [DATA_W:0] s2_dx_reg;
    logic signed [DATA_W:0] s2_dy_reg;
    logic [5:0]             s2_shift_reg;
    side_t                  s2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_dx_reg    <= s1_dx_reg;
            s2_dy_reg    <= s1_dy_reg;
            s2_shift_reg <= 6'(NORM_TARGET) - lead_pos;
            s2_side_reg  <= s2_side_next;
        end
    end

    // stage 3: scale and fold into right half plane
    logic signed [VEC_W-1:0] sx;
    logic signed [VEC_W-1:0] sy;
    assign sx = VEC_W'(s2_dx_reg) <<< s2_shift_reg;
    assign sy = VEC_W'(s2_dy_reg) <<< s2_shift_reg;

    logic                    s3_valid_reg;
    logic signed [VEC_W-1:0] s3_x_reg;
    logic signed [VEC_W-1:0] s3_y_reg;
    logic [ANGLE_W-1:0]      s3_z_reg;
    side_t                   s3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_side_reg <= s2_side_reg;
            if (s2_dx_reg[DATA_W])
            begin
                s3_x_reg <= -sx;
                s3_y_reg <= -sy;
                s3_z_reg <= 32'h8000_0000;
            end
            else
            begin
                s3_x_reg <= sx;
                s3_y_reg <= sy;
                s3_z_reg <= '0;
            end
        end
    end

    logic               c_valid;
    logic [ANGLE_W-1:0] c_z;
    side_t              c_side;
    side_t              c_side_in;
    assign c_side_in = s3_side_reg;

    capu_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (s3_valid_reg),
        .in_x      (s3_x_reg),
        .in_y      (s3_y_reg),
        .in_z      (s3_z_reg),
        .in_side   (c_side_in),
        .out_valid (c_valid),
        .out_z     (c_z),
        .out_side  (c_side)
    );

    // stage 4: quantize, compute unwrap turn count and apply it (zero if radius not positive)
    logic [ANGLE_W:0]         z_round;
    logic signed [DATA_W+1:0] t0;
    logic signed [DATA_W+1:0] diff;
    logic signed [DATA_W+1:0] excess;
    logic signed [9:0]        turns;
    assign z_round = {1'b0, c_z} + 33'd128;
    assign t0      = (DATA_W+2)'(z_round[31:8]);
    assign diff    = t0 - (DATA_W+2)'(c_side.ref_param);

    always_comb
    begin
        turns = '0;
        if (diff > 34'sd8388608)
        begin
            excess = diff - 34'sd8388608 + 34'sd16777215;
            turns  = -10'(excess >>> 24);
        end
        else if (-diff > 34'sd8388608)
        begin
            excess = -diff - 34'sd8388608 + 34'sd16777215;
            turns  = 10'(excess >>> 24);
        end
        else
        begin
            excess = '0;
        end
    end

    logic                     s4_valid_reg;
    logic signed [DATA_W+1:0] s4_t_reg;
    side_t                    s4_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s4_valid_reg <= c_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s4_side_reg <= c_side;
            if (c_side.radius_ok)
            begin
                s4_t_reg <= t0 + {turns, 24'd0};
            end
            else
            begin
                s4_t_reg <= '0;
            end
        end
    end

    // stage 5: saturate, clamp, zero degenerate results, output register
    logic signed [DATA_W-1:0] t_sat;
    logic signed [DATA_W-1:0] t_hi;
    logic signed [DATA_W-1:0] t_fin;

    always_comb
    begin
        if (s4_t_reg > 34'sh0_7FFF_FFFF)
        begin
            t_sat = 32'sh7FFF_FFFF;
        end
        else if (s4_t_reg < -34'sh0_8000_0000)
        begin
            t_sat = 32'sh8000_0000;
        end
        else
        begin
            t_sat = s4_t_reg[DATA_W-1:0];
        end
        t_hi  = (t_sat > s4_side_reg.upper_limit) ? s4_side_reg.upper_limit : t_sat;
        t_fin = (t_hi < s4_side_reg.lower_limit) ? s4_side_reg.lower_limit : t_hi;
        if (s4_side_reg.degenerate)
        begin
            t_fin = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (advance)
        begin
            out_valid <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            param      <= t_fin;
            degenerate <= s4_side_reg.degenerate;
        end
    end

endmodule

// ===== sv/capu_checker.sv =====
// Port-level checker for the circle angle unwrap top level, with bind.
module capu_checker
    import capu_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [DATA_W-1:0] param,
    input logic                     degenerate
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(param))
        else $error("output changed while stalled");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> param == '0)
        else $error("degenerate result not zero");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken during output stall");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

endmodule

bind circle_angle_parameter_unwrap_top capu_checker u_capu_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .param      (param),
    .degenerate (degenerate)
);

// ===== tb/testbench.sv =====
// Testbench for the circle angle unwrap pipeline: random and directed points, predicted.
module testbench;
    import capu_pkg::*;

    typedef struct {
        logic signed [31:0] angle;
        logic               on_center;
    } angle_res_t;

    class angle_scoreboard;
        logic signed [31:0] cx, cy, rad;
        angle_res_t         pending[$];
        int                 errors;
        int                 checked;
        logic [31:0]        atan_lut[0:39];

        function new();
            cx = 0;
            cy = 0;
            rad = 32'sd65536;
            errors = 0;
            checked = 0;
            atan_lut = '{536870912, 316933406, 167458907, 85004756, 42667331,
                         21354465, 10679838, 5340245, 2670163, 1335087,
                         667544, 333772, 166886, 83443, 41722,
                         20861, 10430, 5215, 2608, 1304,
                         652, 326, 163, 81, 41,
                         20, 10, 5, 3, 1,
                         1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        endfunction

        function void set_reg(reg_index_t idx, logic [31:0] val);
            case (idx)
                REG_CENTER_X: cx = val;
                REG_CENTER_Y: cy = val;
                REG_RADIUS:   rad = val;
                default: ;
            endcase
        endfunction

        function longint turns_of(longint dx, longint dy);
            longint mx, my, m, x, y, xs, ys;
            logic [31:0] z;
            int sh;
            mx = dx < 0 ? -dx : dx;
            my = dy < 0 ? -dy : dy;
            m = mx > my ? mx : my;
            sh = 0;
            while (m < (64'sd1 <<< 40))
            begin
                m = m <<< 1;
                sh++;
            end
            x = dx <<< sh;
            y = dy <<< sh;
            z = 0;
            if (x < 0)
            begin
                x = -x;
                y = -y;
                z = 32'h8000_0000;
            end
            for (int i = 0; i < CORDIC_STAGES && i < 40; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + atan_lut[i];
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - atan_lut[i];
                end
            end
            return longint'(((33'(z) + 33'd128) >> 8) & 33'hFF_FFFF);
        endfunction

        function void note_input(logic signed [31:0] px, logic signed [31:0] py,
                                 logic signed [31:0] rp, logic signed [31:0] lo,
                                 logic signed [31:0] hi);
            angle_res_t r;
            longint dx, dy, t, d, ts;
            dx = longint'(px) - longint'(cx);
            dy = longint'(py) - longint'(cy);
            ts = longint'(rp);
            t = 0;
            r.on_center = 0;
            if (rad > 0)
            begin
                if (dx == 0 && dy == 0)
                begin
                    r.angle = 0;
                    r.on_center = 1;
                    pending.push_back(r);
                    return;
                end
                t = turns_of(dx, dy);
                if (t > ts)
                begin
                    d = t - ts;
                    if (d > 64'sd8388608)
                        t = t - (((d - 64'sd8388608 + 64'sd16777215) >>> 24) <<< 24);
                end
                else
                begin
                    d = ts - t;
                    if (d > 64'sd8388608)
                        t = t + (((d - 64'sd8388608 + 64'sd16777215) >>> 24) <<< 24);
                end
                if (t > 64'sd2147483647)
                    t = 64'sd2147483647;
                if (t < -64'sd2147483648)
                    t = -64'sd2147483648;
            end
            if (t > longint'(hi))
                t = hi;
            if (t < longint'(lo))
                t = lo;
            r.angle = t[31:0];
            pending.push_back(r);
        endfunction

        task check_result(logic signed [31:0] p, logic dg);
            angle_res_t e;
            checked++;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("unexpected transfer param=%0d", p));
                return;
            end
            e = pending.pop_front();
            if (p !== e.angle)
                report_mismatch($sformatf("param got %0d want %0d", p, e.angle));
            if (dg !== e.on_center)
                report_mismatch($sformatf("degenerate got %0b want %0b", dg, e.on_center));
        endtask

        task report_mismatch(string msg);
            errors++;
            if (errors <= 30)
                $display("MISMATCH: %s", msg);
        endtask
    endclass

    localparam int LATENCY = CORDIC_STAGES + 5;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] point_x, point_y, ref_param, lower_limit, upper_limit;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] param;
    logic               degenerate;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    angle_scoreboard sb;
    int  cycle_count = 0;
    int  sent;
    bit  quiet_phase;
    bit  hold_off;

    circle_angle_parameter_unwrap_top dut (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 1500000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(param, degenerate);
        if (!rst_n || hold_off)
            out_ready <= 0;
        else if (quiet_phase)
            out_ready <= 1;
        else
            out_ready <= ($urandom_range(99) >= 14);
    end

    always @(posedge clk)
        if (rst_n && in_valid && in_ready)
            sb.note_input(point_x, point_y, ref_param, lower_limit, upper_limit);

    task automatic write_reg(reg_index_t idx, logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, val);
        cfg_valid <= 0;
    endtask

    task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] rp,
                              logic [31:0] lo, logic [31:0] hi);
        while (!quiet_phase && $urandom_range(99) < 14)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        point_x <= px;
        point_y <= py;
        ref_param <= rp;
        lower_limit <= lo;
        upper_limit <= hi;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $urandom_range(200) - 100;
            default: return $signed($urandom) >>> $urandom_range(20);
        endcase
    endfunction

    task automatic random_points(int n);
        logic signed [31:0] lo, hi;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(3) == 0)
            begin
                lo = $urandom;
                hi = $urandom;
            end
            else
            begin
                lo = -($urandom_range(3) << 24) - $urandom_range(1 << 24);
                hi = ($urandom_range(3) << 24) + $urandom_range(1 << 24);
            end
            send_point(rnd_coord(), rnd_coord(),
                       $urandom_range(1) ? $urandom : ($signed($urandom) >>> 5), lo, hi);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 0;
        in_valid = 0;
        cfg_valid = 0;
        cfg_index = REG_CENTER_X;
        cfg_data = 0;
        point_x = 0;
        point_y = 0;
        ref_param = 0;
        lower_limit = 0;
        upper_limit = 0;
        out_ready = 0;
        sent = 0;
        quiet_phase = 0;
        hold_off = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_point(32'h0001_0000, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(0, 32'h0001_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'hFFFF_0000, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(0, 32'hFFFF_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'hFFFF_0000, 32'hFFFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(0, 0, 32'h0100_0000, 32'h0200_0000, 32'h0300_0000);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0080_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'hFFFF_0000, 0, 32'h0100_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(1, 1, 32'h00C0_0000, 32'h0040_0000, 32'h0060_0000);
        send_point(1, 0, 0, 32'h0100_0000, 32'h0080_0000);
        send_point(1, 0, 32'h0080_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        drain();

        write_reg(REG_CENTER_X, 32'h7FFF_FFFF);
        write_reg(REG_CENTER_Y, 32'h8000_0000);
        write_reg(REG_RADIUS, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF);
        random_points(200);
        drain();

        write_reg(REG_RADIUS, 0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h0100_0000, 32'h0200_0000);
        send_point(5, 5, 0, 32'h8000_0000, 32'h7FFF_FFFF);
        random_points(100);
        drain();

        write_reg(REG_RADIUS, 32'h8000_0000);
        write_reg(REG_CENTER_X, 32'h8000_0000);
        write_reg(REG_CENTER_Y, 32'h7FFF_FFFF);
        random_points(100);
        drain();

        write_reg(REG_CENTER_X, $urandom_range(100) - 50);
        write_reg(REG_CENTER_Y, $urandom_range(100) - 50);
        write_reg(REG_RADIUS, 1);
        fork
            begin
                hold_off = 1;
                repeat (3 * LATENCY) @(posedge clk);
                hold_off = 0;
            end
            random_points(600);
        join
        quiet_phase = 1;
        random_points(300);
        quiet_phase = 0;
        random_points(300);
        drain();

        $display("covered %0d points over five register settings, %0d results checked",
                 sent, sb.checked);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
